@@ hw/rtl/tlv_stream_deframer_macros.svh @@
// Assertion macros used by the deframer core RTL.
`ifndef TLV_STREAM_DEFRAMER_MACROS_SVH
`define TLV_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TLVD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TLVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ hw/rtl/tlvd_pkg.sv @@
// Types and constants of the TLV stream deframer.
package tlvd_pkg;

  localparam logic [1:0] ROLE_TAG   = 2'd0;
  localparam logic [1:0] ROLE_LEN   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  localparam logic [3:0] POS_LEN_FIRST = 4'd4;
  localparam logic [3:0] POS_LEN_LAST  = 4'd7;
  localparam logic [3:0] POS_VALUE     = 4'd8;

  localparam logic [0:0] CFG_END_TAG    = 1'd0;
  localparam logic [0:0] CFG_SERIAL_TAG = 1'd1;

  typedef struct packed {
    logic [31:0] end_tag;
    logic [31:0] serial_tag;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  value_byte;
    logic [31:0] record_tag;
    logic [31:0] record_length;
    logic [31:0] value_index;
    logic        record_done;
    logic        message_done;
    logic [31:0] message_bytes;
    logic        serial_valid;
    logic [15:0] serial_value;
    logic        truncated;
  } result_t;

endpackage

@@ hw/rtl/tlvd_cfg_regs.sv @@
// Configuration registers: end tag and serial tag.
module tlvd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output tlvd_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_tag    <= '0;
      cfg.serial_tag <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlvd_pkg::CFG_END_TAG:    cfg.end_tag    <= cfg_data;
        tlvd_pkg::CFG_SERIAL_TAG: cfg.serial_tag <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/tlvd_core.sv @@
// Record parser state and the per-byte result logic.
`include "tlv_stream_deframer_macros.svh"

module tlvd_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  tlvd_pkg::cfg_t     cfg,
  output tlvd_pkg::result_t  res
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [3:0]            header_position, header_position_next;
  logic [31:0]           tag_shift, tag_shift_next;
  logic [31:0]           length_shift, length_shift_next;
  logic [31:0]           value_count, value_count_next;
  logic [COUNT_BITS-1:0] message_count, message_count_next;
  logic [7:0]            serial_first_byte, serial_first_byte_next;
  logic [15:0]           serial_accum, serial_accum_next;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  done;

  always_comb begin
    count_inc = (message_count != COUNT_MAX) ? message_count + 1'b1 : message_count;

    header_position_next   = header_position;
    tag_shift_next         = tag_shift;
    length_shift_next      = length_shift;
    value_count_next       = value_count;
    message_count_next     = count_inc;
    serial_first_byte_next = serial_first_byte;
    serial_accum_next      = serial_accum;
    done                   = 1'b0;

    res               = '0;
    res.value_byte    = data_byte;
    res.message_bytes = 32'(count_inc);

    if (header_position < tlvd_pkg::POS_LEN_FIRST) begin
      res.byte_role = tlvd_pkg::ROLE_TAG;
      if (header_position == '0) begin
        tag_shift_next    = {24'd0, data_byte};
        length_shift_next = '0;
        value_count_next  = '0;
      end else begin
        tag_shift_next = {tag_shift[23:0], data_byte};
      end
      header_position_next = header_position + 4'd1;
    end else if (header_position < tlvd_pkg::POS_VALUE) begin
      res.byte_role        = tlvd_pkg::ROLE_LEN;
      length_shift_next    = {length_shift[23:0], data_byte};
      header_position_next = header_position + 4'd1;
      done = (header_position == tlvd_pkg::POS_LEN_LAST) && (length_shift_next == '0);
    end else begin
      res.byte_role   = tlvd_pkg::ROLE_VALUE;
      res.value_index = value_count;
      if (value_count == 32'd0) begin
        serial_first_byte_next = data_byte;
      end else if (value_count == 32'd1) begin
        serial_accum_next = {serial_first_byte, data_byte};
      end
      value_count_next = value_count + 32'd1;
      done = (value_count_next == length_shift);
    end

    res.record_tag    = tag_shift_next;
    res.record_length = length_shift_next;
    res.record_done   = done;

    if (done) begin
      if (tag_shift_next == cfg.serial_tag) begin
        res.serial_valid = 1'b1;
        res.serial_value = (length_shift_next >= 32'd2) ? serial_accum_next : 16'd0;
      end
      if (tag_shift_next == cfg.end_tag) begin
        res.message_done   = 1'b1;
        message_count_next = '0;
      end
      header_position_next = '0;
    end else if (last_byte) begin
      // drop the partial record and restart the message
      res.truncated        = 1'b1;
      header_position_next = '0;
      message_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position   <= '0;
      tag_shift         <= '0;
      length_shift      <= '0;
      value_count       <= '0;
      message_count     <= '0;
      serial_first_byte <= '0;
      serial_accum      <= '0;
    end else if (en) begin
      header_position   <= header_position_next;
      tag_shift         <= tag_shift_next;
      length_shift      <= length_shift_next;
      value_count       <= value_count_next;
      message_count     <= message_count_next;
      serial_first_byte <= serial_first_byte_next;
      serial_accum      <= serial_accum_next;
    end
  end

  `TLVD_ASSERT_NEXT(a_done_restarts, en && res.record_done, header_position == '0)
  `TLVD_ASSERT_NEXT(a_trunc_clears, en && res.truncated,
                    header_position == '0 && message_count == '0)
  `TLVD_ASSERT_NEXT(a_msg_end_clears, en && res.message_done, message_count == '0)
  `TLVD_ASSERT_NOW(a_serial_quiet, !res.serial_valid, res.serial_value == 16'd0)

endmodule

@@ hw/rtl/tlv_stream_deframer.sv @@
// Pipeline: a byte accepted on s_t* is first held in the input register; its
// parser result is then registered into out_res and shown as a beat on m_t*.
// Throughput: one byte per cycle; each byte's header/value update is one
// register-to-register pass through the parser. m_tready low holds both stages.
// Reset (rst, synchronous): parser waits for a tag byte, message count and
// tag registers are zero, both pipeline registers empty.
module tlv_stream_deframer #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] value_byte, [39:8] record_tag, [71:40] record_length,
  // [103:72] value_index, [135:104] message_bytes, [151:136] serial_value
  output logic [151:0] m_tdata,
  // [1:0] byte_role, [2] record_done, [3] serial_valid, [4] truncated
  output logic [4:0]   m_tuser,
  output logic         m_tlast,   // message_done
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  tlvd_pkg::cfg_t    cfg;
  tlvd_pkg::result_t res;
  tlvd_pkg::result_t out_res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  tlvd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlvd_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on beat, hold otherwise
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.serial_value, out_res.message_bytes, out_res.value_index,
                     out_res.record_length, out_res.record_tag, out_res.value_byte};
  assign m_tuser  = {out_res.truncated, out_res.serial_valid, out_res.record_done,
                     out_res.byte_role};
  assign m_tlast  = out_res.message_done;

endmodule
